// ----- sv/sfss_pkg.sv -----
// Shared types, constants and helper functions for the scale-factor / scfsi block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfss_pkg;

    localparam int SAMPLES_PER_PART = 12;
    localparam int MAX_SUBBANDS     = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CNT_W  = (SAMPLES_PER_PART > 1) ? $clog2(SAMPLES_PER_PART) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [29:0] PEAK_MAX  = 30'h3FFF_FFFF;
    localparam logic [30:0] THRESH_HI = 31'd1704458901;   // 2^(2/3) * 2^30
    localparam logic [30:0] THRESH_LO = 31'd1352829926;   // 2^(1/3) * 2^30

    // part numbers within a group
    localparam logic [1:0] PART_FIRST = 2'd0;
    localparam logic [1:0] PART_LAST  = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHANNEL_COUNT   = 1'b0;
    localparam logic CFG_SUBBANDS_IN_USE = 1'b1;

    // scfsi codes
    localparam logic [1:0] SCFSI_THREE   = 2'd0;
    localparam logic [1:0] SCFSI_SHARE12 = 2'd1;
    localparam logic [1:0] SCFSI_ONE     = 2'd2;
    localparam logic [1:0] SCFSI_SHARE23 = 2'd3;

    localparam logic [4:0] BITS_THREE = 5'd18;
    localparam logic [4:0] BITS_TWO   = 5'd12;
    localparam logic [4:0] BITS_ONE   = 5'd6;

    // which part index each part uses
    typedef enum logic [2:0] {
        P_ABC, P_ABB, P_ACC, P_AAC, P_EXT, P_AAA, P_BBB, P_CCC
    } share_t;

    localparam share_t SHARE_TABLE [0:6][0:6] = '{
        '{P_ABC, P_ABB, P_ABB, P_ABB, P_ACC, P_ACC, P_ABC},
        '{P_AAC, P_AAA, P_AAA, P_AAA, P_EXT, P_EXT, P_AAC},
        '{P_AAC, P_AAA, P_AAA, P_AAA, P_EXT, P_EXT, P_AAC},
        '{P_AAA, P_AAA, P_AAA, P_AAA, P_CCC, P_CCC, P_AAC},
        '{P_BBB, P_BBB, P_BBB, P_BBB, P_CCC, P_CCC, P_ABC},
        '{P_BBB, P_BBB, P_BBB, P_BBB, P_CCC, P_CCC, P_ABC},
        '{P_ABC, P_ABB, P_ABB, P_ABB, P_ACC, P_ACC, P_ABC}
    };

    typedef struct packed {
        logic [29:0] peak;
        logic [1:0]  part;
    } part_t;

    typedef struct packed {
        logic [1:0] channel_count;
        logic [5:0] subbands_in_use;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  sel;
        logic [17:0] word;
        logic [4:0]  bits;
        logic [5:0]  i0;
        logic [5:0]  i1;
        logic [5:0]  i2;
    } group_res_t;

    // exponent = 30 - msb position, floor of the msb at bit 10
    function automatic logic [4:0] peak_exponent(input logic [29:0] peak);
        logic [4:0] e;
        e = 5'd20;
        for (int i = 11; i < 30; i++) begin
            if (peak[i])
                e = 5'(30 - i);
        end
        return e;
    endfunction

    function automatic logic [2:0] clamp_row(input logic signed [6:0] d);
        logic [2:0] r;
        if (d < -7'sd3)
            r = 3'd0;
        else if (d > 7'sd3)
            r = 3'd6;
        else
            r = 3'(d + 7'sd3);
        return r;
    endfunction

    function automatic group_res_t share_pick(input logic [5:0] a, input logic [5:0] b,
                                              input logic [5:0] c);
        logic signed [6:0] d0;
        logic signed [6:0] d1;
        group_res_t res;
        d0 = $signed({1'b0, a}) - $signed({1'b0, b});
        d1 = $signed({1'b0, b}) - $signed({1'b0, c});
        res = '0;
        case (SHARE_TABLE[clamp_row(d0)][clamp_row(d1)])
            P_ABC:
            begin
                res.sel = SCFSI_THREE; res.word = {a, b, c};
                res.i0 = a; res.i1 = b; res.i2 = c;
            end
            P_ABB:
            begin
                res.sel = SCFSI_SHARE23; res.word = {6'd0, a, b};
                res.i0 = a; res.i1 = b; res.i2 = b;
            end
            P_ACC:
            begin
                res.sel = SCFSI_SHARE23; res.word = {6'd0, a, c};
                res.i0 = a; res.i1 = c; res.i2 = c;
            end
            P_AAC:
            begin
                res.sel = SCFSI_SHARE12; res.word = {6'd0, a, c};
                res.i0 = a; res.i1 = a; res.i2 = c;
            end
            P_EXT:
            begin
                // ties keep the first index
                res.sel = SCFSI_ONE;
                if (a > c)
                begin
                    res.word = {12'd0, c}; res.i0 = c; res.i1 = c; res.i2 = c;
                end
                else
                begin
                    res.word = {12'd0, a}; res.i0 = a; res.i1 = a; res.i2 = a;
                end
            end
            P_BBB:
            begin
                res.sel = SCFSI_ONE; res.word = {12'd0, b};
                res.i0 = b; res.i1 = b; res.i2 = b;
            end
            P_CCC:
            begin
                res.sel = SCFSI_ONE; res.word = {12'd0, c};
                res.i0 = c; res.i1 = c; res.i2 = c;
            end
            default:
            begin
                res.sel = SCFSI_ONE; res.word = {12'd0, a};
                res.i0 = a; res.i1 = a; res.i2 = a;
            end
        endcase
        case (res.sel)
            SCFSI_THREE: res.bits = BITS_THREE;
            SCFSI_ONE:   res.bits = BITS_ONE;
            default:     res.bits = BITS_TWO;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sfss_front.sv -----
// Front end: takes samples, tracks the part peak and counts samples and parts.
// Depends on sfss_pkg; pushes one finished part at a time into the queue.
`default_nettype none

module sfss_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [30:0]    sample,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                push_valid,
    output sfss_pkg::part_t     push_entry,
    input  wire logic           push_ready
);
    import sfss_pkg::*;

    logic [29:0]      peak_reg;
    logic [29:0]      peak_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0]       part_reg;
    logic [1:0]       part_next;
    logic [30:0]      mag_full;
    logic [29:0]      mag;
    logic [29:0]      peak_max;
    logic             accept;
    logic             part_done;

    // stall on a full queue, so a part end always finds room
    assign in_stall = !push_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        // negation mod 2^31; only full-scale negative reaches bit 30
        mag_full  = sample[30] ? (31'd0 - sample) : sample;
        mag       = mag_full[30] ? PEAK_MAX : mag_full[29:0];
        peak_max  = (mag > peak_reg) ? mag : peak_reg;
        part_done = (cnt_reg == CNT_W'(SAMPLES_PER_PART - 1));

        peak_next = peak_reg;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        if (accept)
        begin
            if (part_done)
            begin
                peak_next = '0;
                cnt_next  = '0;
                part_next = (part_reg == PART_LAST) ? PART_FIRST : part_reg + 2'd1;
            end
            else
            begin
                peak_next = peak_max;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
        end
    end

    assign push_valid      = accept && part_done;
    assign push_entry.peak = peak_max;
    assign push_entry.part = part_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            cnt_reg  <= '0;
            part_reg <= PART_FIRST;
        end
        else
        begin
            peak_reg <= peak_next;
            cnt_reg  <= cnt_next;
            part_reg <= part_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sfss_queue.sv -----
// Short register queue of finished parts between front and back end.
// Depends on sfss_pkg for the entry type and depth.
`default_nettype none

module sfss_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire sfss_pkg::part_t push_entry,
    output logic                 push_ready,
    output logic                 pop_valid,
    output sfss_pkg::part_t      pop_entry,
    input  wire logic            pop_ready
);
    import sfss_pkg::*;

    part_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- sv/sfss_back.sv -----
// Back end: scale index per part, sharing pattern per group, output register.
// Depends on sfss_pkg; takes parts from sfss_queue and the config from the top.
`default_nettype none

module sfss_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sfss_pkg::cfg_t  cfg,
    input  wire logic            pop_valid,
    input  wire sfss_pkg::part_t pop_entry,
    output logic                 pop_ready,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 channel,
    output logic [4:0]           subband,
    output logic [1:0]           selector_info,
    output logic [17:0]          factor_word,
    output logic [4:0]           factor_bits,
    output logic [5:0]           index_first,
    output logic [5:0]           index_second,
    output logic [5:0]           index_third,
    output logic                 frame_last
);
    import sfss_pkg::*;

    // stage 1: exponent found
    logic        s1_valid_reg;
    logic [29:0] s1_peak_reg;
    logic [4:0]  s1_exp_reg;
    logic [1:0]  s1_part_reg;
    // index of parts one and two of the group in progress
    logic [5:0]  part_idx_reg [2];
    // stage 2: complete group
    logic        grp_valid_reg;
    logic [5:0]  grp_a_reg;
    logic [5:0]  grp_b_reg;
    logic [5:0]  grp_c_reg;
    // group position
    logic        ch_now_reg;
    logic        ch_now_next;
    logic [4:0]  sb_now_reg;
    logic [4:0]  sb_now_next;
    // output register
    logic        out_valid_reg;
    group_res_t  res_reg;
    logic        ch_out_reg;
    logic [4:0]  sb_out_reg;
    logic        last_out_reg;

    logic [30:0] norm;
    logic [1:0]  mclass;
    logic [5:0]  idx;
    logic        s1_go;
    logic        grp_go;
    logic        s1_to_grp;
    logic [5:0]  sb_lim;
    logic        ch_last;
    logic        sb_last;
    group_res_t  res;

    assign grp_go    = grp_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_go     = s1_valid_reg
                       && ((s1_part_reg != PART_LAST) || !grp_valid_reg || grp_go);
    assign s1_to_grp = s1_go && (s1_part_reg == PART_LAST);
    assign pop_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        norm   = 31'(s1_peak_reg) << s1_exp_reg;
        mclass = {1'b0, (norm < THRESH_HI)} + {1'b0, (norm < THRESH_LO)};
        idx    = {s1_exp_reg, 1'b0} + {1'b0, s1_exp_reg} + {4'd0, mclass};
    end

    always_comb
    begin
        res = share_pick(grp_a_reg, grp_b_reg, grp_c_reg);

        // channel count 0 acts as 1, 3 as 2; subbands clamp to 1..MAX_SUBBANDS
        if (cfg.subbands_in_use == '0)
            sb_lim = 6'd1;
        else if (cfg.subbands_in_use > 6'(MAX_SUBBANDS))
            sb_lim = 6'(MAX_SUBBANDS);
        else
            sb_lim = cfg.subbands_in_use;
        ch_last = !cfg.channel_count[1] || ch_now_reg;
        sb_last = (({1'b0, sb_now_reg} + 6'd1) >= sb_lim);

        ch_now_next = ch_now_reg;
        sb_now_next = sb_now_reg;
        if (grp_go)
        begin
            if (ch_last)
            begin
                ch_now_next = 1'b0;
                sb_now_next = sb_last ? 5'd0 : sb_now_reg + 5'd1;
            end
            else
            begin
                ch_now_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            s1_peak_reg <= pop_entry.peak;
            s1_exp_reg  <= peak_exponent(pop_entry.peak);
            s1_part_reg <= pop_entry.part;
        end
        if (s1_go && (s1_part_reg != PART_LAST))
            part_idx_reg[s1_part_reg[0]] <= idx;
        if (s1_to_grp)
        begin
            grp_a_reg <= part_idx_reg[0];
            grp_b_reg <= part_idx_reg[1];
            grp_c_reg <= idx;
        end
        if (grp_go)
        begin
            res_reg      <= res;
            ch_out_reg   <= ch_now_reg;
            sb_out_reg   <= sb_now_reg;
            last_out_reg <= ch_last && sb_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_now_reg    <= 1'b0;
            sb_now_reg    <= '0;
        end
        else
        begin
            if (pop_ready)
                s1_valid_reg <= pop_valid;
            if (s1_to_grp)
                grp_valid_reg <= 1'b1;
            else if (grp_go)
                grp_valid_reg <= 1'b0;
            if (grp_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            ch_now_reg <= ch_now_next;
            sb_now_reg <= sb_now_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel       = ch_out_reg;
    assign subband       = sb_out_reg;
    assign selector_info = res_reg.sel;
    assign factor_word   = res_reg.word;
    assign factor_bits   = res_reg.bits;
    assign index_first   = res_reg.i0;
    assign index_second  = res_reg.i1;
    assign index_third   = res_reg.i2;
    assign frame_last    = last_out_reg;

endmodule

`default_nettype wire

// ----- sv/scale_factor_scfsi_select_top.sv -----
// Top level of the scale-factor / scfsi selector: config registers and wiring
// of sfss_front, sfss_queue and sfss_back. Depends on sfss_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------
//   input    | in        | in_valid / in_stall  | sample
//   result   | out       | out_valid / out_stall| channel, subband, selector_info,
//            |           |                      | factor_word, factor_bits, index_*,
//            |           |                      | frame_last
//   config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle while in_stall is low. A group result passes through the queue,
// exponent stage, group stage and output register after its last sample.
// in_stall rises only when the two-entry part queue is full, i.e. after a
// stalled output has backed up the group and exponent stages.
// Reset clears counters, peak and all valid flags; config returns to 1 channel
// and 32 subbands. cfg_ready is always high.
`default_nettype none

module scale_factor_scfsi_select_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [30:0]    sample,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic                channel,
    output logic [4:0]          subband,
    output logic [1:0]          selector_info,
    output logic [17:0]         factor_word,
    output logic [4:0]          factor_bits,
    output logic [5:0]          index_first,
    output logic [5:0]          index_second,
    output logic [5:0]          index_third,
    output logic                frame_last,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [5:0]     cfg_data
);
    import sfss_pkg::*;

    cfg_t  cfg_reg;
    logic  push_valid;
    part_t push_entry;
    logic  push_ready;
    logic  pop_valid;
    part_t pop_entry;
    logic  pop_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count   <= 2'd1;
            cfg_reg.subbands_in_use <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT:   cfg_reg.channel_count   <= cfg_data[1:0];
                CFG_SUBBANDS_IN_USE: cfg_reg.subbands_in_use <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    sfss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    sfss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop_ready     (pop_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel       (channel),
        .subband       (subband),
        .selector_info (selector_info),
        .factor_word   (factor_word),
        .factor_bits   (factor_bits),
        .index_first   (index_first),
        .index_second  (index_second),
        .index_third   (index_third),
        .frame_last    (frame_last)
    );

endmodule

`default_nettype wire
